>>> hdl/mmpu_pkg.sv
// Shared constants and types for the modular multiply / power unit.
package mmpu_pkg;

    localparam int FIELD_BITS    = 64;
    localparam int WORD_BITS_DEF = 64;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

endpackage

>>> hdl/mmpu_mulmod.sv
// Bit-serial modular multiplier: (x * y) mod m, one bit of y at a time, MSB first.
module mmpu_mulmod #(
    parameter int WORD_BITS = mmpu_pkg::WORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WORD_BITS-1:0]  i_x,
    input  logic [WORD_BITS-1:0]  i_y,
    input  logic [WORD_BITS-1:0]  i_mod,
    output mmpu_pkg::t_mm_status  o_status,
    output logic [WORD_BITS-1:0]  o_product
);

    localparam int CNT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    logic                 r_busy;
    logic                 r_done;
    logic                 r_phase;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_x;
    logic [WORD_BITS-1:0] r_y;

    logic [WORD_BITS-1:0] n_opnd;
    logic [WORD_BITS:0]   n_sum;
    logic [WORD_BITS+1:0] n_diff;
    logic [WORD_BITS-1:0] n_addmod;

    // acc + opnd, reduced once; both operands are below the modulus
    assign n_opnd   = r_phase ? r_x : r_acc;
    assign n_sum    = {1'b0, r_acc} + {1'b0, n_opnd};
    assign n_diff   = {1'b0, n_sum} - {2'b00, i_mod};
    assign n_addmod = n_diff[WORD_BITS+1] ? n_sum[WORD_BITS-1:0] : n_diff[WORD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= CNT_BITS'(WORD_BITS - 1);
                r_acc   <= '0;
                r_x     <= i_x;
                r_y     <= i_y;
            end else if (r_busy) begin
                if (!r_phase) begin
                    r_acc   <= n_addmod;
                    r_phase <= 1'b1;
                end else begin
                    if (r_y[WORD_BITS-1]) begin
                        r_acc <= n_addmod;
                    end
                    r_y     <= {r_y[WORD_BITS-2:0], 1'b0};
                    r_phase <= 1'b0;
                    if (r_cnt == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_product     = r_acc;

endmodule

>>> hdl/modular_mul_pow_unit_core.sv
// Top level of the modular multiply / power unit: sequencer and channel registers.
//
//  channel | direction | beat                                  | handshake
//  --------+-----------+---------------------------------------+-----------------------
//  in      | input     | action, base_value, second_operand    | i_in_valid / o_in_stall
//  out     | output    | result_value                          | o_out_valid / i_out_stall
//  cfg     | input     | modulus                               | i_cfg_valid / o_cfg_ready
//
// Multiply: two passes of the serial multiplier (base reduction, then product).
// Power: one reduction plus one pass per exponent bit and per set bit, up to
// about 2*WORD_BITS passes; stops after the top set bit.
// One item at a time; a finished beat waits in the output register while the next
// item is taken. Synchronous reset sets the modulus to 1.
module modular_mul_pow_unit_core #(
    parameter int WORD_BITS = mmpu_pkg::WORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mmpu_pkg::FIELD_BITS-1:0] i_cfg_modulus,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_action,
    input  logic [mmpu_pkg::FIELD_BITS-1:0] i_base_value,
    input  logic [mmpu_pkg::FIELD_BITS-1:0] i_second_operand,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [mmpu_pkg::FIELD_BITS-1:0] o_result_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_MUL,
        S_PCHK,
        S_PMUL,
        S_PSQ,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [WORD_BITS-1:0] r_mod;
    logic                 r_act;
    logic [WORD_BITS-1:0] r_opb;
    logic [WORD_BITS-1:0] r_exp;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_sq;
    logic [WORD_BITS-1:0] r_res;
    logic                 r_start;
    logic [WORD_BITS-1:0] r_x;
    logic [WORD_BITS-1:0] r_y;
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_data;

    mmpu_pkg::t_mm_status mm_status;
    logic [WORD_BITS-1:0] mm_product;
    logic [WORD_BITS-1:0] n_one;
    logic                 n_in_acc;
    logic                 n_out_free;

    assign n_one      = {{(WORD_BITS-1){1'b0}}, (r_mod != WORD_BITS'(1))};
    assign n_in_acc   = i_in_valid && !o_in_stall;
    assign n_out_free = !r_out_valid || !i_out_stall;

    mmpu_mulmod #(
        .WORD_BITS (WORD_BITS)
    ) u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_x       (r_x),
        .i_y       (r_y),
        .i_mod     (r_mod),
        .o_status  (mm_status),
        .o_product (mm_product)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mod       <= WORD_BITS'(1);
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mod <= i_cfg_modulus[WORD_BITS-1:0];
            end
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_in_acc) begin
                        r_act <= i_action;
                        r_opb <= i_second_operand[WORD_BITS-1:0];
                        r_exp <= i_second_operand[WORD_BITS-1:0];
                        if (r_mod == '0) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_x     <= n_one;
                            r_y     <= i_base_value[WORD_BITS-1:0];
                            r_start <= 1'b1;
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (mm_status.done) begin
                        if (!r_act) begin
                            r_x     <= mm_product;
                            r_y     <= r_opb;
                            r_start <= 1'b1;
                            r_state <= S_MUL;
                        end else begin
                            r_sq    <= mm_product;
                            r_acc   <= n_one;
                            r_state <= S_PCHK;
                        end
                    end
                end
                S_MUL: begin
                    if (mm_status.done) begin
                        r_res   <= mm_product;
                        r_state <= S_DONE;
                    end
                end
                S_PCHK: begin
                    if (r_exp == '0) begin
                        r_res   <= r_acc;
                        r_state <= S_DONE;
                    end else if (r_exp[0]) begin
                        r_x     <= r_acc;
                        r_y     <= r_sq;
                        r_start <= 1'b1;
                        r_state <= S_PMUL;
                    end else begin
                        r_x     <= r_sq;
                        r_y     <= r_sq;
                        r_start <= 1'b1;
                        r_state <= S_PSQ;
                    end
                end
                S_PMUL: begin
                    if (mm_status.done) begin
                        r_acc <= mm_product;
                        if (r_exp[WORD_BITS-1:1] == '0) begin
                            r_res   <= mm_product;
                            r_state <= S_DONE;
                        end else begin
                            r_x     <= r_sq;
                            r_y     <= r_sq;
                            r_start <= 1'b1;
                            r_state <= S_PSQ;
                        end
                    end
                end
                S_PSQ: begin
                    if (mm_status.done) begin
                        r_sq    <= mm_product;
                        r_exp   <= {1'b0, r_exp[WORD_BITS-1:1]};
                        r_state <= S_PCHK;
                    end
                end
                S_DONE: begin
                    if (n_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_in_stall     = (r_state != S_IDLE) || mm_status.busy;
    assign o_out_valid    = r_out_valid;
    assign o_result_value = mmpu_pkg::FIELD_BITS'(r_out_data);

endmodule

>>> hdl/mmpu_checker.sv
// Port-level checker for the modular multiply / power unit, with its bind.
module mmpu_checker #(
    parameter int WORD_BITS = mmpu_pkg::WORD_BITS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [mmpu_pkg::FIELD_BITS-1:0] i_cfg_modulus,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [mmpu_pkg::FIELD_BITS-1:0] o_result_value
);

    logic [WORD_BITS-1:0] r_mod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= WORD_BITS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mod <= i_cfg_modulus[WORD_BITS-1:0];
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat valid right after reset");

    a_one_item_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item taken while one is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_result_value)))
        else $error("stalled output beat changed");

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((r_mod == '0) ? (o_result_value == '0)
                           : (o_result_value[WORD_BITS-1:0] < r_mod)))
        else $error("result not reduced below modulus");

endmodule

bind modular_mul_pow_unit_core mmpu_checker #(
    .WORD_BITS (WORD_BITS)
) u_mmpu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cfg_valid    (i_cfg_valid),
    .o_cfg_ready    (o_cfg_ready),
    .i_cfg_modulus  (i_cfg_modulus),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_value (o_result_value)
);
